### hw/rtl/pwmfd_pkg.sv
// Shared types and constants for the pulse-width Manchester frame decoder.
package pwmfd_pkg;

   localparam int THRESHOLD_BITS = 15;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 15'd600;
   localparam int START_HALF_BITS = 2;
   localparam int DATA_BITS = 16;
   localparam int BYTE_BITS = 8;
   localparam int DECODE_SPAN = START_HALF_BITS + 2 * DATA_BITS;

   typedef struct packed {
      logic first_level;
      logic first_double;
      logic second_level;
      logic second_double;
      logic frame_end;
   } phase_pair_type;

endpackage

### hw/rtl/pwmfd_front.sv
// Front end: threshold register and classification of each pulse pair into half-bits.
module pwmfd_front #(
   parameter int DURATION_BITS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pwmfd_pkg::THRESHOLD_BITS-1:0] csr_wdata,
   input  logic                                first_level,
   input  logic [DURATION_BITS-1:0]            first_duration,
   input  logic                                second_level,
   input  logic [DURATION_BITS-1:0]            second_duration,
   input  logic                                frame_end,
   output pwmfd_pkg::phase_pair_type           pair
);
   import pwmfd_pkg::*;

   logic [THRESHOLD_BITS-1:0] threshold_ff;
   logic [THRESHOLD_BITS-1:0] threshold_in;
   logic [DURATION_BITS-1:0]  threshold_cmp;

   always_comb begin
      threshold_in = csr_we ? csr_wdata : threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign threshold_cmp = DURATION_BITS'(threshold_ff);

   always_comb begin
      pair.first_level   = first_level;
      pair.first_double  = first_duration > threshold_cmp;
      pair.second_level  = second_level;
      pair.second_double = second_duration > threshold_cmp;
      pair.frame_end     = frame_end;
   end

endmodule

### hw/rtl/pwmfd_queue.sv
// Two-entry queue of classified pulse pairs between the front and back ends.
module pwmfd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pwmfd_pkg::phase_pair_type push_data,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output pwmfd_pkg::phase_pair_type head_data
);
   import pwmfd_pkg::*;

   phase_pair_type entry_ff [2];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;
   logic           do_push;
   logic           do_pop;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/pwmfd_back.sv
// Back end: half-bit store, frame decode and the registered result.
module pwmfd_back #(
   parameter int HALF_BIT_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  pwmfd_pkg::phase_pair_type         head_data,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pwmfd_pkg::BYTE_BITS-1:0]   rsp_address_byte,
   output logic [pwmfd_pkg::BYTE_BITS-1:0]   rsp_data_byte,
   output logic                              rsp_bit_error
);
   import pwmfd_pkg::*;

   localparam int CNT_BITS = $clog2(HALF_BIT_DEPTH + 1);

   logic [DECODE_SPAN-1:0] store_ff;
   logic [DECODE_SPAN-1:0] store_in;
   logic [DECODE_SPAN-1:0] store_next;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;
   logic [CNT_BITS:0]      count_sum;
   logic [3:0]             seq;
   logic [2:0]             n_half;
   logic [CNT_BITS-1:0]    offset [DECODE_SPAN];
   logic [DATA_BITS-1:0]   word;
   logic                   err;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [BYTE_BITS-1:0]   address_ff;
   logic [BYTE_BITS-1:0]   data_ff;
   logic                   error_ff;

   assign pop = head_valid && (!head_data.frame_end || !rsp_valid_ff || rsp_ready);

   always_comb begin
      seq[0] = head_data.first_level;
      seq[1] = head_data.first_double ? head_data.first_level : head_data.second_level;
      seq[2] = head_data.second_level;
      seq[3] = head_data.second_level;
      n_half = 3'd2 + {2'b00, head_data.first_double} + {2'b00, head_data.second_double};
   end

   always_comb begin
      for (int p = 0; p < DECODE_SPAN; p++) begin
         offset[p] = CNT_BITS'(p) - count_ff;
         if ((count_ff <= CNT_BITS'(p)) && (offset[p] < CNT_BITS'(n_half))) begin
            store_next[p] = seq[offset[p][1:0]];
         end else begin
            store_next[p] = store_ff[p];
         end
      end
      count_sum = {1'b0, count_ff} + (CNT_BITS + 1)'(n_half);
      if (count_sum > (CNT_BITS + 1)'(HALF_BIT_DEPTH)) begin
         count_in = CNT_BITS'(HALF_BIT_DEPTH);
      end else begin
         count_in = count_sum[CNT_BITS-1:0];
      end
   end

   always_comb begin
      word = '0;
      err  = 1'b0;
      for (int i = 0; i < DATA_BITS; i++) begin
         word[DATA_BITS-1-i] = store_next[START_HALF_BITS + 2*i]
                             & !store_next[START_HALF_BITS + 2*i + 1];
         if (store_next[START_HALF_BITS + 2*i] == store_next[START_HALF_BITS + 2*i + 1]) begin
            err = 1'b1;
         end
      end
   end

   always_comb begin
      store_in = store_ff;
      if (pop) begin
         store_in = head_data.frame_end ? '0 : store_next;
      end
      if (pop && head_data.frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         store_ff     <= store_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            count_ff <= head_data.frame_end ? '0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_data.frame_end) begin
         address_ff <= word[DATA_BITS-1:BYTE_BITS];
         data_ff    <= word[BYTE_BITS-1:0];
         error_ff   <= err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_address_byte = address_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_bit_error    = error_ff;

endmodule

### hw/rtl/pulse_width_manchester_frame_decoder.sv
// Pulse-width Manchester frame decoder: one pulse pair per cycle in while
// req_ready is high, one decoded 16-bit frame out per frame end. Each pair
// is classified against the threshold as it is accepted and placed in a
// two-entry queue; the back end takes one pair per cycle from that queue
// unless a frame end waits behind an untaken result, appends its two to four
// half-bits and, on a frame end, decodes the frame into the output register.
// The sustained rate is one pair per cycle; input stalls only while a finished
// result waits to be taken and a further frame end has reached the queue head.
module pulse_width_manchester_frame_decoder #(
   parameter int HALF_BIT_DEPTH = 64,
   parameter int DURATION_BITS  = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pwmfd_pkg::THRESHOLD_BITS-1:0] csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_first_level,
   input  logic [DURATION_BITS-1:0]            req_first_duration,
   input  logic                                req_second_level,
   input  logic [DURATION_BITS-1:0]            req_second_duration,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pwmfd_pkg::BYTE_BITS-1:0]     rsp_address_byte,
   output logic [pwmfd_pkg::BYTE_BITS-1:0]     rsp_data_byte,
   output logic                                rsp_bit_error
);
   import pwmfd_pkg::*;

   phase_pair_type pair;
   phase_pair_type head_data;
   logic           queue_full;
   logic           head_valid;
   logic           pop;

   pwmfd_front #(
      .DURATION_BITS(DURATION_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .first_level    (req_first_level),
      .first_duration (req_first_duration),
      .second_level   (req_second_level),
      .second_duration(req_second_duration),
      .frame_end      (req_frame_end),
      .pair           (pair)
   );

   pwmfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (pair),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   pwmfd_back #(
      .HALF_BIT_DEPTH(HALF_BIT_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_address_byte(rsp_address_byte),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_bit_error   (rsp_bit_error)
   );

   assign req_ready = !queue_full;

endmodule

### hw/rtl/pwmfd_checker.sv
// Port-level checker for the frame decoder and its bind to the top level.
module pwmfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_address_byte,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_bit_error
);

   // After reset the queue is empty and no result is pending.
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("decoder not idle after reset");

   // The queue can only fill when the result register was stalled the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("input stalled without a stalled result");

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address_byte)
         && $stable(rsp_data_byte) && $stable(rsp_bit_error))
      else $error("result changed before transfer");

endmodule

bind pulse_width_manchester_frame_decoder pwmfd_checker u_pwmfd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_address_byte(rsp_address_byte),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_bit_error   (rsp_bit_error)
);
